@@ rtl/b32c_pkg.sv @@
package b32c_pkg;

    // Symbol set: 'A'..'Z' for 0..25, '1'..'6' for 26..31
    localparam logic [7:0] CHAR_A   = 8'h41;
    localparam logic [7:0] CHAR_Z   = 8'h5A;
    localparam logic [7:0] CHAR_ONE = 8'h31;
    localparam logic [7:0] CHAR_SIX = 8'h36;
    localparam logic [4:0] DIGIT_SPLIT = 5'd26;

    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    localparam int MAX_RESULTS = 3;

    typedef struct packed {
        logic       last;
        logic       status;
        logic [7:0] data;
    } result_t;

    // Results produced by one input word, entry 0 leaves first
    typedef struct packed {
        logic [1:0]                  count;
        result_t [MAX_RESULTS-1:0]   res;
    } bundle_t;

    typedef struct packed {
        logic       valid;
        logic [4:0] value;
    } symval_t;

    // Map a 5-bit value to its symbol character
    function automatic logic [7:0] sym_of(input logic [4:0] v);
        logic [7:0] ch;
        if (v < DIGIT_SPLIT) begin
            ch = CHAR_A + {3'd0, v};
        end else begin
            ch = CHAR_ONE + {3'd0, v - DIGIT_SPLIT};
        end
        return ch;
    endfunction

    // Map a character to its 5-bit value and a valid flag
    function automatic symval_t val_of(input logic [7:0] c);
        symval_t sv;
        logic [7:0] diff;
        sv = '0;
        if (c >= CHAR_A && c <= CHAR_Z) begin
            diff = c - CHAR_A;
            sv.valid = 1'b1;
            sv.value = diff[4:0];
        end else if (c >= CHAR_ONE && c <= CHAR_SIX) begin
            diff = c - CHAR_ONE;
            sv.valid = 1'b1;
            sv.value = diff[4:0] + DIGIT_SPLIT;
        end
        return sv;
    endfunction

endpackage

@@ rtl/b32c_core.sv @@
module b32c_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic                 cfg_wdata,
    input  logic                 accept,
    input  logic [7:0]           in_byte,
    input  logic                 in_last,
    output b32c_pkg::bundle_t    bundle
);

    logic        mode_reg;
    logic [11:0] bit_buffer_reg, bit_buffer_next;
    logic [3:0]  bit_count_reg, bit_count_next;
    logic        error_seen_reg, error_seen_next;

    // Encode path signals
    logic [11:0] enc_buf;
    logic [3:0]  enc_cnt, enc_r1, enc_r2, enc_rem;
    logic [11:0] enc_sh1, enc_sh2, enc_rest, enc_padded;
    logic        enc_two, enc_pad;
    logic [7:0]  enc_sym1, enc_sym2, enc_sym_pad;

    // Decode path signals
    b32c_pkg::symval_t dec_sv;
    logic [11:0] dec_buf, dec_sh, dec_rest;
    logic [3:0]  dec_cnt, dec_rem;
    logic        dec_full;

    // Encode datapath: append byte, cut up to two 5-bit groups, pad leftover
    always_comb begin
        enc_buf    = {bit_buffer_reg[3:0], in_byte};
        enc_cnt    = bit_count_reg + 4'd8;
        enc_r1     = enc_cnt - 4'd5;
        enc_sh1    = enc_buf >> enc_r1;
        enc_two    = (enc_r1 >= 4'd5);
        enc_r2     = enc_r1 - 4'd5;
        enc_sh2    = enc_buf >> enc_r2;
        enc_rem    = enc_two ? enc_r2 : enc_r1;
        enc_rest   = enc_buf & ((12'd1 << enc_rem) - 12'd1);
        enc_padded = enc_rest << (4'd5 - enc_rem);
        enc_pad    = in_last && (enc_rem != 4'd0);
        enc_sym1   = b32c_pkg::sym_of(enc_sh1[4:0]);
        enc_sym2   = b32c_pkg::sym_of(enc_sh2[4:0]);
        enc_sym_pad = b32c_pkg::sym_of(enc_padded[4:0]);
    end

    // Decode datapath: append 5 bits, cut one byte when 8 are pending
    always_comb begin
        dec_sv   = b32c_pkg::val_of(in_byte);
        dec_buf  = {bit_buffer_reg[6:0], dec_sv.value};
        dec_cnt  = bit_count_reg + 4'd5;
        dec_full = (dec_cnt >= 4'd8);
        dec_rem  = dec_cnt - 4'd8;
        dec_sh   = dec_buf >> dec_rem;
        dec_rest = dec_buf & ((12'd1 << dec_rem) - 12'd1);
    end

    // Select results and next state for the accepted word
    always_comb begin
        bundle          = '0;
        bit_buffer_next = bit_buffer_reg;
        bit_count_next  = bit_count_reg;
        error_seen_next = error_seen_reg;
        if (mode_reg == b32c_pkg::MODE_ENCODE) begin
            bundle.res[0].data = enc_sym1;
            if (enc_two) begin
                bundle.res[1].data = enc_sym2;
                bundle.res[2].data = enc_sym_pad;
            end else begin
                bundle.res[1].data = enc_sym_pad;
            end
            bundle.count = 2'd1 + {1'b0, enc_two} + {1'b0, enc_pad};
            bundle.res[0].last = in_last && (bundle.count == 2'd1);
            bundle.res[1].last = in_last && (bundle.count == 2'd2);
            bundle.res[2].last = in_last && (bundle.count == 2'd3);
            if (in_last) begin
                bit_buffer_next = '0;
                bit_count_next  = '0;
            end else begin
                bit_buffer_next = enc_rest;
                bit_count_next  = enc_rem;
            end
        end else if (error_seen_reg) begin
            // Drop the rest of a bad message
            if (in_last) begin
                bit_buffer_next = '0;
                bit_count_next  = '0;
                error_seen_next = 1'b0;
            end
        end else if (!dec_sv.valid) begin
            bundle.count         = 2'd1;
            bundle.res[0].status = 1'b1;
            bundle.res[0].last   = 1'b1;
            bit_buffer_next      = '0;
            bit_count_next       = '0;
            error_seen_next      = !in_last;
        end else begin
            if (dec_full) begin
                bundle.count       = 2'd1;
                bundle.res[0].data = dec_sh[7:0];
                bundle.res[0].last = in_last;
                bit_buffer_next    = dec_rest;
                bit_count_next     = dec_rem;
            end else begin
                bit_buffer_next = dec_buf;
                bit_count_next  = dec_cnt;
            end
            if (in_last) begin
                bit_buffer_next = '0;
                bit_count_next  = '0;
            end
        end
    end

    // Hold mode and pending bits; a mode write abandons the message
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= b32c_pkg::MODE_ENCODE;
            bit_buffer_reg <= '0;
            bit_count_reg  <= '0;
            error_seen_reg <= 1'b0;
        end else if (cfg_we) begin
            mode_reg       <= cfg_wdata;
            bit_buffer_reg <= '0;
            bit_count_reg  <= '0;
            error_seen_reg <= 1'b0;
        end else if (accept) begin
            bit_buffer_reg <= bit_buffer_next;
            bit_count_reg  <= bit_count_next;
            error_seen_reg <= error_seen_next;
        end
    end

endmodule

@@ rtl/b32c_out.sv @@
module b32c_out (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  b32c_pkg::bundle_t   bundle,
    output logic                room,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata,
    output logic                m_tuser,
    output logic                m_tlast
);

    b32c_pkg::result_t [b32c_pkg::MAX_RESULTS-1:0] ent_reg;
    logic [1:0] num_reg;
    logic       take;

    assign take     = m_tvalid && m_tready;
    assign m_tvalid = (num_reg != 2'd0);
    assign m_tdata  = ent_reg[0].data;
    assign m_tuser  = ent_reg[0].status;
    assign m_tlast  = ent_reg[0].last;

    // Take a new bundle when the queue is empty or its last pending word is leaving
    assign room = (num_reg == 2'd0) || ((num_reg == 2'd1) && m_tready);

    // Pending word count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_reg <= '0;
        end else if (load) begin
            num_reg <= bundle.count;
        end else if (take) begin
            num_reg <= num_reg - 2'd1;
        end
    end

    // Load a bundle, or advance the queue by one word
    always_ff @(posedge aclk) begin
        if (load) begin
            ent_reg <= bundle.res;
        end else if (take) begin
            ent_reg[0] <= ent_reg[1];
            ent_reg[1] <= ent_reg[2];
        end
    end

endmodule

@@ rtl/base32_codec.sv @@
// Streaming base32 codec, symbols 'A'-'Z' then '1'-'6', no padding. cfg_wdata
// selects encode (0) or decode (1); any write restarts the message in progress
// and is to be made by the user only while the block is idle, which the block
// itself does not enforce. Encoding turns each byte into one to three symbols
// (the last byte of a message flushes leftover bits as a zero-padded symbol);
// decoding turns symbols into bytes and drops leftover bits at the end. An
// invalid symbol gives one word with m_tuser set and m_tlast set, and the rest
// of that message up to s_tlast gives nothing. The results of an input word,
// N of them (0 or 1 decoding, 1 to 3 encoding), are registered in the
// three-entry output queue and offered from the cycle after the word is taken;
// the queue empties one word per cycle while m_tready is high, and the next
// input word is taken only when the queue is empty or its last result leaves.
module base32_codec (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_data
    output logic       m_tuser,   // [0] out_status
    output logic       m_tlast
);

    b32c_pkg::bundle_t bundle;
    logic              accept;

    assign accept = s_tvalid && s_tready;

    b32c_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .in_byte   (s_tdata),
        .in_last   (s_tlast),
        .bundle    (bundle)
    );

    b32c_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (accept),
        .bundle   (bundle),
        .room     (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
